### rtl/hmtp_pkg.sv
// ----------------------------------------------------------------------------
// Height map text parser package
// Shared types and constants for the text parser and the point scaler.
// ----------------------------------------------------------------------------
package hmtp_pkg;

  typedef enum logic [1:0] {
    PH_BETWEEN,
    PH_HEIGHT,
    PH_PREFIX,
    PH_HEX
  } phase_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  localparam logic [23:0] WHITE      = 24'hFFFFFF;
  localparam logic [2:0]  HEX_DIGITS = 3'd6;
  localparam logic [15:0] HEIGHT_SAT = 16'd32768;
  localparam logic [15:0] HEIGHT_MAX = 16'd32767;

  localparam int XY_W    = 10;
  localparam int Z_W     = 7;
  localparam int POS_W   = 20;
  localparam int HZ_W    = 23;
  localparam int COLOR_W = 24;

  localparam logic REG_XY_SCALE = 1'b0;
  localparam logic REG_Z_SCALE  = 1'b1;

  typedef struct packed {
    logic signed [15:0] height;
    logic [23:0]        color;
    logic               final_pt;
  } point_t;

endpackage

### rtl/hmtp_parser.sv
// ----------------------------------------------------------------------------
// Height map text parser: token parser
// Parses one text byte per request, tracks grid position and registers one
// finished point with its column and row.
// ----------------------------------------------------------------------------
module hmtp_parser
  import hmtp_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  parameter int CW = $clog2(MAX_COLS + 1),
  parameter int RW = $clog2(MAX_ROWS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    text_byte,
  input  logic          end_of_text,
  output logic          pt_valid,
  input  logic          pt_ready,
  output logic [CW-1:0] pt_col,
  output logic [RW-1:0] pt_row,
  output point_t        pt
);

  phase_t        phase, phase_next;
  logic [15:0]   acc, acc_next;
  logic          neg, neg_next;
  logic [23:0]   color, color_next;
  logic [2:0]    cnt, cnt_next;
  logic          has, has_next;
  logic [CW-1:0] lwidth, lwidth_next;
  logic          wk, wk_next;
  logic [CW-1:0] cc, cc_next;
  logic [RW-1:0] rc, rc_next;

  logic          sep, digit, minus, comma, xch, hex_ok;
  logic [3:0]    hex_val;
  logic [18:0]   acc_mul;
  logic          do_finish, emit;
  logic [CW-1:0] col_out, cc_inc;
  logic [RW-1:0] row_out;
  logic signed [15:0] height_out;
  logic [23:0]   color_out;
  logic          accept;

  assign sep    = (text_byte == CH_SPACE) || (text_byte == CH_NL);
  assign digit  = text_byte inside {[8'h30:8'h39]};
  assign minus  = (text_byte == CH_MINUS);
  assign comma  = (text_byte == CH_COMMA);
  assign xch    = (text_byte == CH_X_LO) || (text_byte == CH_X_UP);
  assign hex_ok = digit || (text_byte inside {[8'h41:8'h46], [8'h61:8'h66]});
  assign hex_val = digit ? text_byte[3:0] : text_byte[3:0] + 4'd9;
  assign acc_mul = {acc, 3'b000} + 19'({acc, 1'b0}) + 19'(text_byte[3:0]);
  assign cc_inc  = cc + CW'(1);

  assign in_ready = !pt_valid || pt_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_next  = phase;
    acc_next    = acc;
    neg_next    = neg;
    color_next  = color;
    cnt_next    = cnt;
    has_next    = has;
    lwidth_next = lwidth;
    wk_next     = wk;
    cc_next     = cc;
    rc_next     = rc;
    emit        = 1'b0;
    col_out     = cc;
    row_out     = '0;

    if (!sep) begin
      case (phase)
        PH_BETWEEN: begin
          if (digit) begin
            phase_next = PH_HEIGHT;
            acc_next   = 16'(text_byte[3:0]);
            neg_next   = 1'b0;
          end else if (minus) begin
            phase_next = PH_HEIGHT;
            acc_next   = '0;
            neg_next   = 1'b1;
          end
        end
        PH_HEIGHT: begin
          if (digit) begin
            acc_next = (acc_mul > 19'(HEIGHT_SAT)) ? HEIGHT_SAT : acc_mul[15:0];
          end else if (comma) begin
            phase_next = PH_PREFIX;
          end
        end
        PH_PREFIX: begin
          if (xch) phase_next = PH_HEX;
        end
        PH_HEX: begin
          if (hex_ok && cnt < HEX_DIGITS) begin
            color_next = {color[19:0], hex_val};
            cnt_next   = cnt + 3'd1;
            has_next   = 1'b1;
          end
        end
        default: phase_next = PH_BETWEEN;
      endcase
    end

    if (neg_next) begin
      height_out = 16'(-{1'b0, acc_next});
    end else begin
      height_out = (acc_next > HEIGHT_MAX) ? HEIGHT_MAX : acc_next;
    end
    color_out = has_next ? color_next : WHITE;

    do_finish = (sep || end_of_text) && (phase_next != PH_BETWEEN);
    if (do_finish) begin
      if (!wk) begin
        if (cc < CW'(MAX_COLS)) begin
          cc_next = cc_inc;
          emit    = 1'b1;
        end
      end else begin
        row_out = rc;
        if (rc < RW'(MAX_ROWS)) begin
          emit = 1'b1;
          if (cc_inc >= lwidth) begin
            cc_next = '0;
            rc_next = rc + RW'(1);
          end else begin
            cc_next = cc_inc;
          end
        end
      end
      phase_next = PH_BETWEEN;
      acc_next   = '0;
      neg_next   = 1'b0;
      color_next = '0;
      cnt_next   = '0;
      has_next   = 1'b0;
    end

    if (text_byte == CH_NL && !wk && cc_next != '0) begin
      lwidth_next = cc_next;
      wk_next     = 1'b1;
      cc_next     = '0;
      rc_next     = RW'(1);
    end

    if (end_of_text) begin
      phase_next  = PH_BETWEEN;
      acc_next    = '0;
      neg_next    = 1'b0;
      color_next  = '0;
      cnt_next    = '0;
      has_next    = 1'b0;
      lwidth_next = '0;
      wk_next     = 1'b0;
      cc_next     = '0;
      rc_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_BETWEEN;
      acc    <= '0;
      neg    <= 1'b0;
      color  <= '0;
      cnt    <= '0;
      has    <= 1'b0;
      lwidth <= '0;
      wk     <= 1'b0;
      cc     <= '0;
      rc     <= '0;
    end else if (accept) begin
      phase  <= phase_next;
      acc    <= acc_next;
      neg    <= neg_next;
      color  <= color_next;
      cnt    <= cnt_next;
      has    <= has_next;
      lwidth <= lwidth_next;
      wk     <= wk_next;
      cc     <= cc_next;
      rc     <= rc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (in_ready) begin
      pt_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      pt_col      <= col_out;
      pt_row      <= row_out;
      pt.height   <= height_out;
      pt.color    <= color_out;
      pt.final_pt <= end_of_text;
    end
  end

endmodule

### rtl/hmtp_scaler.sv
// ----------------------------------------------------------------------------
// Height map text parser: point scaler
// Holds the scale registers and multiplies a parsed point into the output
// register.
// ----------------------------------------------------------------------------
module hmtp_scaler
  import hmtp_pkg::*;
#(
  parameter int CW = 11,
  parameter int RW = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [XY_W-1:0]    cfg_data,
  input  logic               pt_valid,
  output logic               pt_ready,
  input  logic [CW-1:0]      pt_col,
  input  logic [RW-1:0]      pt_row,
  input  point_t             pt,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [POS_W-1:0]   pos_x,
  output logic [POS_W-1:0]   pos_y,
  output logic [HZ_W-1:0]    height_z,
  output logic [COLOR_W-1:0] color,
  output logic               final_point
);

  localparam int PXW = CW + XY_W;
  localparam int PYW = RW + XY_W;

  logic [XY_W-1:0]   xy_scale;
  logic [Z_W-1:0]    z_scale;
  logic [PXW-1:0]    prod_x;
  logic [PYW-1:0]    prod_y;
  logic signed [23:0] prod_z;

  assign pt_ready = !out_valid || out_ready;
  assign prod_x   = PXW'(pt_col) * PXW'(xy_scale);
  assign prod_y   = PYW'(pt_row) * PYW'(xy_scale);
  assign prod_z   = 24'(pt.height) * $signed({17'd0, z_scale});

  always_ff @(posedge clk) begin
    if (rst) begin
      xy_scale <= XY_W'(1);
      z_scale  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_XY_SCALE: xy_scale <= cfg_data;
        REG_Z_SCALE:  z_scale  <= cfg_data[Z_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pt_ready) begin
      out_valid <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_ready && pt_valid) begin
      pos_x       <= POS_W'(prod_x);
      pos_y       <= POS_W'(prod_y);
      height_z    <= prod_z[HZ_W-1:0];
      color       <= pt.color;
      final_point <= pt.final_pt;
    end
  end

endmodule

### rtl/height_map_text_parser.sv
// ----------------------------------------------------------------------------
// Height map text parser
// Turns a byte stream of map text into scaled grid points.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle unless stalled; the byte that closes a token
// gives a point through two registers: one after the parser, one after the
// scale multipliers. Both stages advance whenever the stage after them is
// empty or drained, so s_tready follows m_tready through both registers and a
// full stream runs at one byte per clock while m_tready stays high. The row
// width comes from the first line that holds a token; s_tlast flushes any open
// token and resets the parser, while xy_scale and z_scale keep their values.
module height_map_text_parser
  import hmtp_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [XY_W-1:0] cfg_data,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // text_byte
  input  logic            s_tlast,   // end_of_text
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [87:0]     m_tdata,   // pos_x, pos_y, height_z, color, zero pad
  output logic            m_tlast    // final_point
);

  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);

  logic          pt_valid;
  logic          pt_ready;
  logic [CW-1:0] pt_col;
  logic [RW-1:0] pt_row;
  point_t        pt;

  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [HZ_W-1:0]    height_z;
  logic [COLOR_W-1:0] color;

  hmtp_parser #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW),
    .RW       (RW)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .text_byte   (s_tdata),
    .end_of_text (s_tlast),
    .pt_valid    (pt_valid),
    .pt_ready    (pt_ready),
    .pt_col      (pt_col),
    .pt_row      (pt_row),
    .pt          (pt)
  );

  hmtp_scaler #(
    .CW (CW),
    .RW (RW)
  ) u_scaler (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pt_valid    (pt_valid),
    .pt_ready    (pt_ready),
    .pt_col      (pt_col),
    .pt_row      (pt_row),
    .pt          (pt),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .height_z    (height_z),
    .color       (color),
    .final_point (m_tlast)
  );

  assign m_tdata = {1'b0, color, height_z, pos_y, pos_x};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_point_moves_out: assert property (@(posedge clk) disable iff (rst)
    (pt_valid && pt_ready) |=> m_tvalid)
    else $error("parsed point lost before output register");

  a_point_held: assert property (@(posedge clk) disable iff (rst)
    (pt_valid && !pt_ready) |=> (pt_valid && $stable(pt) && $stable(pt_col)))
    else $error("parsed point changed while stalled");

endmodule
